// ===== hw/rtl/tpdt_pkg.sv =====
`default_nettype none
package tpdt_pkg;

  // screen size defaults
  localparam int SCREEN_WIDTH_DEF  = 800;
  localparam int SCREEN_HEIGHT_DEF = 600;

  // fixed arithmetic widths, set by the field widths
  localparam int CRD_W  = 13;  // coordinate
  localparam int DIF_W  = 14;  // coordinate difference
  localparam int PRD_W  = 28;  // difference product
  localparam int EDG_W  = 29;  // edge value
  localparam int VZ_W   = 16;  // vertex depth
  localparam int ZW_W   = 45;  // depth times edge
  localparam int SUM_W  = 47;  // weighted depth sum
  localparam int AREA_W = 28;  // positive area magnitude
  localparam int DVD_W  = 51;  // area * 100 * 65536
  localparam int CNT_W  = 6;   // divider step counter
  localparam int COL_W  = 24;
  localparam int DEP_W  = 32;
  localparam int PIX_W  = 10;

  localparam int DEPTH_SCALE = 100;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_TEST  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PROD,
    ST_EDGE,
    ST_WSUM,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/triangle_pixel_depth_test.sv =====
`default_nettype none
// channel  | ports                                              | handshake
// input    | in_action, in_vertex_slot, in_coord_x, in_coord_y, | start && !busy
//          | in_vertex_depth, in_tri_color                      |
// result   | out_write_enable, out_pixel_x, out_pixel_y,        | out_valid, one cycle
//          | out_pixel_color, out_pixel_depth                   |
//
// every item gives one result; load, clear, unused and off-screen items give it
// in the cycle after acceptance and busy stays low
// a covered test item reaches its result through four arithmetic steps, then the
// restoring divider producing one quotient bit per cycle over 51 bits, then
// the depth compare and write back; busy is high meanwhile
// after reset the depth memory is swept to zero, one entry a cycle, over all
// SCREEN_WIDTH*SCREEN_HEIGHT entries (480000 by default) with busy high
// the receiver cannot stall, results are taken as they appear
module triangle_pixel_depth_test #(
  parameter int SCREEN_WIDTH  = tpdt_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tpdt_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire  [1:0]                        in_action,
  input  wire  [1:0]                        in_vertex_slot,
  input  wire  signed [tpdt_pkg::CRD_W-1:0] in_coord_x,
  input  wire  signed [tpdt_pkg::CRD_W-1:0] in_coord_y,
  input  wire  signed [tpdt_pkg::VZ_W-1:0]  in_vertex_depth,
  input  wire  [tpdt_pkg::COL_W-1:0]        in_tri_color,
  output logic                              out_valid,
  output logic                              out_write_enable,
  output logic [tpdt_pkg::PIX_W-1:0]        out_pixel_x,
  output logic [tpdt_pkg::PIX_W-1:0]        out_pixel_y,
  output logic [tpdt_pkg::COL_W-1:0]        out_pixel_color,
  output logic [tpdt_pkg::DEP_W-1:0]        out_pixel_depth
);

  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = tpdt_pkg::CRD_W;
  localparam int DW    = tpdt_pkg::DIF_W;
  localparam int PW    = tpdt_pkg::PRD_W;
  localparam int EW    = tpdt_pkg::EDG_W;
  localparam int SW    = tpdt_pkg::SUM_W;
  localparam int QW    = tpdt_pkg::DVD_W;
  localparam int DEPW  = tpdt_pkg::DEP_W;
  localparam int MW    = tpdt_pkg::AREA_W + 7;

  tpdt_pkg::state_t state_r, state_nxt;

  // triangle registers
  logic signed [CW-1:0]                 vx_r [3];
  logic signed [CW-1:0]                 vy_r [3];
  logic signed [tpdt_pkg::VZ_W-1:0]     vz_r [3];
  logic [tpdt_pkg::COL_W-1:0]           color_r;

  // current pixel
  logic signed [CW-1:0] px_r, py_r;
  logic [AW-1:0]        idx_r;

  // arithmetic pipeline registers
  logic signed [PW-1:0]          pa_r [4];
  logic signed [PW-1:0]          pb_r [4];
  logic signed [EW-1:0]          edge_r [4];
  logic signed [tpdt_pkg::ZW_W-1:0] zw_r [3];
  logic [QW-1:0]                 dvd_r;
  logic [SW-1:0]                 divisor_r;
  logic [SW-1:0]                 rem_r;
  logic [QW-1:0]                 quo_r;
  logic [tpdt_pkg::CNT_W-1:0]    div_cnt_r;

  logic [AW-1:0] sweep_cnt_r;

  // depth memory
  logic [DEPW-1:0] depth_mem [DEPTH];
  logic [DEPW-1:0] rd_data_r;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [DEPW-1:0] mem_wdata;
  logic            mem_re;

  // result registers
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_we_r, out_we_nxt;
  logic [tpdt_pkg::PIX_W-1:0]   out_x_r, out_y_r, out_x_nxt, out_y_nxt;
  logic [tpdt_pkg::COL_W-1:0]   out_color_r, out_color_nxt;
  logic [DEPW-1:0]              out_depth_r, out_depth_nxt;

  logic                accept;
  logic                on_screen;
  logic [AW-1:0]       in_idx;
  logic                edge_reject;
  logic signed [SW-1:0] sum;
  logic                sum_reject;
  logic [SW-1:0]       rem_sh;
  logic                rem_ge;
  logic                div_last;
  logic [DEPW-1:0]     q_final;
  logic                closer;
  logic                sweep_last;

  // edge operand selection: area, w0, w1, w2
  logic signed [CW-1:0] ea_x [4], ea_y [4], eb_x [4], eb_y [4], ec_x [4], ec_y [4];
  logic signed [DW-1:0] d_cx [4], d_cy [4], d_bx [4], d_by [4];

  assign busy   = (state_r != tpdt_pkg::ST_IDLE);
  assign accept = start && !busy;

  // pixel must lie inside the screen
  assign on_screen = !in_coord_x[CW-1] && !in_coord_y[CW-1] &&
                     ({1'b0, in_coord_x[CW-2:0]} < CW'(SCREEN_WIDTH)) &&
                     ({1'b0, in_coord_y[CW-2:0]} < CW'(SCREEN_HEIGHT));
  assign in_idx = AW'(AW'(in_coord_y[CW-2:0]) * AW'(SCREEN_WIDTH)) +
                  AW'(in_coord_x[CW-2:0]);

  always_comb begin
    ea_x[0] = vx_r[0]; ea_y[0] = vy_r[0]; eb_x[0] = vx_r[1]; eb_y[0] = vy_r[1];
    ec_x[0] = vx_r[2]; ec_y[0] = vy_r[2];
    ea_x[1] = vx_r[1]; ea_y[1] = vy_r[1]; eb_x[1] = vx_r[2]; eb_y[1] = vy_r[2];
    ec_x[1] = px_r;    ec_y[1] = py_r;
    ea_x[2] = vx_r[2]; ea_y[2] = vy_r[2]; eb_x[2] = vx_r[0]; eb_y[2] = vy_r[0];
    ec_x[2] = px_r;    ec_y[2] = py_r;
    ea_x[3] = vx_r[0]; ea_y[3] = vy_r[0]; eb_x[3] = vx_r[1]; eb_y[3] = vy_r[1];
    ec_x[3] = px_r;    ec_y[3] = py_r;
    for (int k = 0; k < 4; k++) begin
      d_cx[k] = DW'(ec_x[k]) - DW'(ea_x[k]);
      d_cy[k] = DW'(ec_y[k]) - DW'(ea_y[k]);
      d_bx[k] = DW'(eb_x[k]) - DW'(ea_x[k]);
      d_by[k] = DW'(eb_y[k]) - DW'(ea_y[k]);
    end
  end

  // reject on a negative edge value or a non-positive area
  assign edge_reject = edge_r[1][EW-1] || edge_r[2][EW-1] || edge_r[3][EW-1] ||
                       edge_r[0][EW-1] || (edge_r[0] == '0);

  assign sum = SW'(zw_r[0]) + SW'(zw_r[1]) + SW'(zw_r[2]);
  assign sum_reject = sum[SW-1] || (sum == '0);

  // restoring divider, one quotient bit a cycle
  assign rem_sh   = {rem_r[SW-2:0], dvd_r[QW-1]};
  assign rem_ge   = (rem_sh >= divisor_r);
  assign div_last = (div_cnt_r == tpdt_pkg::CNT_W'(QW - 1));

  // saturate when the quotient needs more than 32 bits
  assign q_final = (|quo_r[QW-1:DEPW]) ? '1 : quo_r[DEPW-1:0];
  assign closer  = (q_final > rd_data_r);

  assign sweep_last = (sweep_cnt_r == AW'(DEPTH - 1));

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = '0;
    mem_re    = accept && (in_action == tpdt_pkg::ACT_TEST) && on_screen;
    case (state_r)
      tpdt_pkg::ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_cnt_r;
      end
      tpdt_pkg::ST_IDLE: begin
        mem_we    = accept && (in_action == tpdt_pkg::ACT_CLEAR) && on_screen;
        mem_waddr = in_idx;
      end
      tpdt_pkg::ST_DONE: begin
        mem_we    = closer;
        mem_wdata = q_final;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      depth_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= depth_mem[in_idx];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tpdt_pkg::ST_SWEEP: if (sweep_last) state_nxt = tpdt_pkg::ST_IDLE;
      tpdt_pkg::ST_IDLE: begin
        if (accept && (in_action == tpdt_pkg::ACT_TEST) && on_screen) begin
          state_nxt = tpdt_pkg::ST_PROD;
        end
      end
      tpdt_pkg::ST_PROD: state_nxt = tpdt_pkg::ST_EDGE;
      tpdt_pkg::ST_EDGE: state_nxt = tpdt_pkg::ST_WSUM;
      tpdt_pkg::ST_WSUM: state_nxt = edge_reject ? tpdt_pkg::ST_IDLE : tpdt_pkg::ST_SUM;
      tpdt_pkg::ST_SUM:  state_nxt = sum_reject ? tpdt_pkg::ST_IDLE : tpdt_pkg::ST_DIV;
      tpdt_pkg::ST_DIV:  if (div_last) state_nxt = tpdt_pkg::ST_DONE;
      tpdt_pkg::ST_DONE: state_nxt = tpdt_pkg::ST_IDLE;
      default:           state_nxt = tpdt_pkg::ST_IDLE;
    endcase
  end

  // result for the next cycle, zero payload unless a pixel is written
  always_comb begin
    out_valid_nxt = 1'b0;
    out_we_nxt    = 1'b0;
    out_x_nxt     = '0;
    out_y_nxt     = '0;
    out_color_nxt = '0;
    out_depth_nxt = '0;
    case (state_r)
      tpdt_pkg::ST_IDLE: begin
        if (accept) begin
          // an on-screen test answers later, everything else right away
          out_valid_nxt = !((in_action == tpdt_pkg::ACT_TEST) && on_screen);
          if ((in_action == tpdt_pkg::ACT_CLEAR) && on_screen) begin
            out_we_nxt = 1'b1;
            out_x_nxt  = in_coord_x[tpdt_pkg::PIX_W-1:0];
            out_y_nxt  = in_coord_y[tpdt_pkg::PIX_W-1:0];
          end
        end
      end
      tpdt_pkg::ST_WSUM: out_valid_nxt = edge_reject;
      tpdt_pkg::ST_SUM:  out_valid_nxt = sum_reject;
      tpdt_pkg::ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_we_nxt    = closer;
        if (closer) begin
          out_x_nxt     = px_r[tpdt_pkg::PIX_W-1:0];
          out_y_nxt     = py_r[tpdt_pkg::PIX_W-1:0];
          out_color_nxt = color_r;
          out_depth_nxt = q_final;
        end
      end
      default: out_valid_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tpdt_pkg::ST_SWEEP;
      sweep_cnt_r <= '0;
      out_valid_r <= 1'b0;
      out_we_r    <= 1'b0;
      out_x_r     <= '0;
      out_y_r     <= '0;
      out_color_r <= '0;
      out_depth_r <= '0;
      color_r     <= '0;
      for (int k = 0; k < 3; k++) begin
        vx_r[k] <= '0;
        vy_r[k] <= '0;
        vz_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_we_r    <= out_we_nxt;
      out_x_r     <= out_x_nxt;
      out_y_r     <= out_y_nxt;
      out_color_r <= out_color_nxt;
      out_depth_r <= out_depth_nxt;
      if (state_r == tpdt_pkg::ST_SWEEP) begin
        sweep_cnt_r <= sweep_cnt_r + AW'(1);
      end
      // a bad vertex slot changes nothing
      if (accept && (in_action == tpdt_pkg::ACT_LOAD) && (in_vertex_slot != 2'd3)) begin
        vx_r[in_vertex_slot] <= in_coord_x;
        vy_r[in_vertex_slot] <= in_coord_y;
        vz_r[in_vertex_slot] <= in_vertex_depth;
        color_r              <= in_tri_color;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      tpdt_pkg::ST_IDLE: begin
        if (accept && (in_action == tpdt_pkg::ACT_TEST)) begin
          px_r  <= in_coord_x;
          py_r  <= in_coord_y;
          idx_r <= in_idx;
        end
      end
      tpdt_pkg::ST_PROD: begin
        for (int k = 0; k < 4; k++) begin
          pa_r[k] <= PW'(d_cx[k]) * PW'(d_by[k]);
          pb_r[k] <= PW'(d_cy[k]) * PW'(d_bx[k]);
        end
      end
      tpdt_pkg::ST_EDGE: begin
        for (int k = 0; k < 4; k++) begin
          edge_r[k] <= EW'(pa_r[k]) - EW'(pb_r[k]);
        end
      end
      tpdt_pkg::ST_WSUM: begin
        for (int k = 0; k < 3; k++) begin
          zw_r[k] <= tpdt_pkg::ZW_W'(vz_r[k]) * tpdt_pkg::ZW_W'(edge_r[k+1]);
        end
        dvd_r <= {MW'(edge_r[0][tpdt_pkg::AREA_W-1:0]) * MW'(tpdt_pkg::DEPTH_SCALE),
                  16'h0000};
      end
      tpdt_pkg::ST_SUM: begin
        divisor_r <= sum;
        rem_r     <= '0;
        quo_r     <= '0;
        div_cnt_r <= '0;
      end
      tpdt_pkg::ST_DIV: begin
        rem_r     <= rem_ge ? (rem_sh - divisor_r) : rem_sh;
        quo_r     <= {quo_r[QW-2:0], rem_ge};
        dvd_r     <= {dvd_r[QW-2:0], 1'b0};
        div_cnt_r <= div_cnt_r + tpdt_pkg::CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = out_we_r;
  assign out_pixel_x      = out_x_r;
  assign out_pixel_y      = out_y_r;
  assign out_pixel_color  = out_color_r;
  assign out_pixel_depth  = out_depth_r;

  // load, clear and unused items answer in the next cycle
  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_action != tpdt_pkg::ACT_TEST)) |=> out_valid)
    else $error("quick item gave no result");

  // a write is only reported with a result strobe
  a_we_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_write_enable |-> out_valid)
    else $error("write enable without result");

  // divider step count stays inside the quotient width
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tpdt_pkg::ST_DIV) |-> (div_cnt_r < tpdt_pkg::CNT_W'(QW)))
    else $error("divider overran");

  // the arithmetic tail always ends in exactly one result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tpdt_pkg::ST_DONE) |=> (out_valid && !busy))
    else $error("test item lost its result");

endmodule
`default_nettype wire
